### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SHA-256 engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is high.
`define HSHA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsha assertion failed");
// Next-cycle implication, disabled while reset is high.
`define HSHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsha assertion failed");
`endif

### design/hsha_pkg.sv
// ----------------------------------------------------------------------------
// hsha_pkg
// Types, constants and round functions shared by the SHA-256 engine.
// ----------------------------------------------------------------------------
package hsha_pkg;

   localparam logic KIND_KEY = 1'b0;
   localparam logic KIND_MSG = 1'b1;

   localparam logic [31:0] IPAD_WORD = 32'h3636_3636;
   localparam logic [31:0] OPAD_WORD = 32'h5c5c_5c5c;
   localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
   localparam logic [31:0] OUTER_BITS = 32'd768;
   localparam logic [7:0]  PAD_BYTE  = 8'h80;

   localparam logic [31:0] IV_VAL [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_START, OP_APPEND, OP_CINIT, OP_ROUND, OP_ADD,
      OP_CLOSE, OP_KEYPLAIN, OP_PAD, OP_LEN, OP_KEYHASH, OP_OPAD, OP_OUTER,
      OP_IV
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_APPEND, ST_FINCHK, ST_KEYST, ST_PAD, ST_LEN,
      ST_DONE, ST_OUTER, ST_CINIT, ST_ROUND, ST_ADD, ST_SEND
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] widx;
   } cmd_type;

   typedef struct packed {
      logic new_stream;
      logic kind;
      logic hmac_mode;
      logic msg_hmac;
      logic full;
      logic ovf;
      logic left_zero;
      logic fin;
      logic p_hi;
      logic round_last;
   } status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

### design/hsha_datapath.sv
// ----------------------------------------------------------------------------
// hsha_datapath
// Block buffer, key store, chaining value, round unit and stream counters.
// ----------------------------------------------------------------------------
module hsha_datapath
   import hsha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  st,
   input  logic        req_kind,
   input  logic [63:0] req_chunk,
   input  logic [3:0]  req_byte_count,
   input  logic        req_final_chunk,
   input  logic        csr_valid,
   input  logic        csr_hmac_mode,
   output logic [63:0] rsp_digest_word
);

   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];
   logic [31:0] key_ff [16];
   logic [31:0] key_in [16];
   logic [31:0] cv_ff [8];
   logic [31:0] cv_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] inner_ff [8];
   logic [31:0] inner_in [8];
   logic [63:0] chunk_ff, chunk_in;
   logic [3:0]  left_ff, left_in;
   logic        fin_ff, fin_in;
   logic        kind_ff, kind_in;
   logic [63:0] cnt_ff, cnt_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        full_ff, full_in;
   logic        ovf_ff, ovf_in;
   logic        open_ff, open_in;
   logic        okind_ff, okind_in;
   logic        mhmac_ff, mhmac_in;
   logic        mode_ff, mode_in;

   logic [5:0]  pos;
   logic [63:0] cnt_inc;
   logic [63:0] len_bits;
   logic [31:0] t1, t2, w_new;
   logic [5:0]  bpos;
   logic [7:0]  bval;

   assign pos      = cnt_ff[5:0];
   assign cnt_inc  = cnt_ff + 64'd1;
   assign len_bits = {cnt_ff[60:0], 3'b000};

   assign t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + round_k(rnd_ff) + blk_ff[0];
   assign t2 = bsig0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign w_new = ssig1(blk_ff[14]) + blk_ff[9] + ssig0(blk_ff[1]) + blk_ff[0];

   always_comb begin
      blk_in   = blk_ff;
      key_in   = key_ff;
      cv_in    = cv_ff;
      v_in     = v_ff;
      inner_in = inner_ff;
      chunk_in = chunk_ff;
      left_in  = left_ff;
      fin_in   = fin_ff;
      kind_in  = kind_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      full_in  = full_ff;
      ovf_in   = ovf_ff;
      open_in  = open_ff;
      okind_in = okind_ff;
      mhmac_in = mhmac_ff;
      mode_in  = csr_valid ? csr_hmac_mode : mode_ff;
      bpos     = '0;
      bval     = '0;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LATCH: begin
            chunk_in = req_chunk;
            left_in  = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
            fin_in   = req_final_chunk;
            kind_in  = req_kind;
         end
         OP_START: begin
            open_in  = 1'b1;
            okind_in = kind_ff;
            ovf_in   = 1'b0;
            full_in  = 1'b0;
            cv_in    = IV_VAL;
            mhmac_in = (kind_ff == KIND_MSG) && mode_ff;
            cnt_in   = ((kind_ff == KIND_MSG) && mode_ff) ? 64'd64 : 64'd0;
            for (int i = 0; i < 16; i++) begin
               blk_in[i] = key_ff[i] ^ IPAD_WORD;
            end
         end
         OP_APPEND: begin
            for (int i = 0; i < 16; i++) begin
               for (int j = 0; j < 4; j++) begin
                  bpos = 6'(i * 4 + j);
                  if (bpos == pos) begin
                     blk_in[i][31 - 8 * j -: 8] = chunk_ff[63:56];
                  end
               end
            end
            cnt_in   = cnt_inc;
            chunk_in = {chunk_ff[55:0], 8'h00};
            left_in  = left_ff - 4'd1;
            if ((kind_ff == KIND_KEY) && ((cnt_inc[63:7] != '0) || (cnt_inc[6:0] > 7'd64))) begin
               ovf_in = 1'b1;
            end
            if (pos == 6'd63) begin
               full_in = 1'b1;
            end
         end
         OP_CINIT: begin
            v_in    = cv_ff;
            rnd_in  = '0;
            full_in = 1'b0;
         end
         OP_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               blk_in[i] = blk_ff[i + 1];
            end
            blk_in[15] = w_new;
            rnd_in = rnd_ff + 6'd1;
         end
         OP_ADD: begin
            for (int i = 0; i < 8; i++) begin
               cv_in[i] = cv_ff[i] + v_ff[i];
            end
         end
         OP_CLOSE: begin
            open_in = 1'b0;
         end
         OP_KEYPLAIN: begin
            for (int i = 0; i < 16; i++) begin
               for (int j = 0; j < 4; j++) begin
                  bpos = 6'(i * 4 + j);
                  bval = blk_ff[i][31 - 8 * j -: 8];
                  if ((cnt_ff[63:6] == '0) && (bpos >= pos)) begin
                     bval = 8'h00;
                  end
                  key_in[i][31 - 8 * j -: 8] = bval;
               end
            end
            cv_in = IV_VAL;
         end
         OP_PAD: begin
            for (int i = 0; i < 16; i++) begin
               for (int j = 0; j < 4; j++) begin
                  bpos = 6'(i * 4 + j);
                  if (bpos == pos) begin
                     blk_in[i][31 - 8 * j -: 8] = PAD_BYTE;
                  end else if (bpos > pos) begin
                     blk_in[i][31 - 8 * j -: 8] = 8'h00;
                  end
               end
            end
            if (pos[5:3] != 3'b111) begin
               blk_in[14] = len_bits[63:32];
               blk_in[15] = len_bits[31:0];
            end
         end
         OP_LEN: begin
            for (int i = 0; i < 14; i++) begin
               blk_in[i] = '0;
            end
            blk_in[14] = len_bits[63:32];
            blk_in[15] = len_bits[31:0];
         end
         OP_KEYHASH: begin
            for (int i = 0; i < 8; i++) begin
               key_in[i]     = cv_ff[i];
               key_in[i + 8] = '0;
            end
            cv_in = IV_VAL;
         end
         OP_OPAD: begin
            inner_in = cv_ff;
            cv_in    = IV_VAL;
            for (int i = 0; i < 16; i++) begin
               blk_in[i] = key_ff[i] ^ OPAD_WORD;
            end
         end
         OP_OUTER: begin
            for (int i = 0; i < 8; i++) begin
               blk_in[i]     = inner_ff[i];
               blk_in[i + 8] = '0;
            end
            blk_in[8]  = PAD_WORD;
            blk_in[15] = OUTER_BITS;
         end
         OP_IV: begin
            cv_in = IV_VAL;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      blk_ff   <= blk_in;
      v_ff     <= v_in;
      inner_ff <= inner_in;
      chunk_ff <= chunk_in;
      left_ff  <= left_in;
      fin_ff   <= fin_in;
      kind_ff  <= kind_in;
      rnd_ff   <= rnd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '{default: '0};
         cv_ff    <= IV_VAL;
         cnt_ff   <= '0;
         full_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         open_ff  <= 1'b0;
         okind_ff <= KIND_KEY;
         mhmac_ff <= 1'b0;
         mode_ff  <= 1'b0;
      end else begin
         key_ff   <= key_in;
         cv_ff    <= cv_in;
         cnt_ff   <= cnt_in;
         full_ff  <= full_in;
         ovf_ff   <= ovf_in;
         open_ff  <= open_in;
         okind_ff <= okind_in;
         mhmac_ff <= mhmac_in;
         mode_ff  <= mode_in;
      end
   end

   assign st.new_stream = !open_ff || (okind_ff != req_kind);
   assign st.kind       = kind_ff;
   assign st.hmac_mode  = mode_ff;
   assign st.msg_hmac   = mhmac_ff;
   assign st.full       = full_ff;
   assign st.ovf        = ovf_ff;
   assign st.left_zero  = (left_ff == '0);
   assign st.fin        = fin_ff;
   assign st.p_hi       = (pos[5:3] == 3'b111);
   assign st.round_last = (rnd_ff == 6'd63);

   assign rsp_digest_word = {cv_ff[{cmd.widx, 1'b0}], cv_ff[{cmd.widx, 1'b1}]};

endmodule

### design/hsha_ctrl.sv
// ----------------------------------------------------------------------------
// hsha_ctrl
// Sequencer for byte appending, padding, compression and digest output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsha_ctrl
   import hsha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type st,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic [1:0] widx_ff, widx_in;
   logic       outer_ff, outer_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         widx_ff  <= '0;
         outer_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         widx_ff  <= widx_in;
         outer_ff <= outer_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      widx_in   = widx_ff;
      outer_in  = outer_ff;
      cmd.op    = OP_NONE;
      cmd.widx  = widx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            outer_in  = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = st.new_stream ? ST_START : ST_APPEND;
            end
         end
         ST_START: begin
            cmd.op = OP_START;
            if ((st.kind == KIND_MSG) && st.hmac_mode) begin
               ret_in   = ST_APPEND;
               state_in = ST_CINIT;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (st.left_zero) begin
               state_in = ST_FINCHK;
            end else if (st.full) begin
               ret_in   = ST_APPEND;
               state_in = ST_CINIT;
            end else begin
               cmd.op = OP_APPEND;
            end
         end
         ST_FINCHK: begin
            if (!st.fin) begin
               state_in = ST_IDLE;
            end else begin
               cmd.op = OP_CLOSE;
               if ((st.kind == KIND_KEY) && !st.ovf) begin
                  state_in = ST_KEYST;
               end else if (st.full) begin
                  ret_in   = ST_PAD;
                  state_in = ST_CINIT;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_KEYST: begin
            cmd.op   = OP_KEYPLAIN;
            state_in = ST_IDLE;
         end
         ST_PAD: begin
            cmd.op   = OP_PAD;
            ret_in   = st.p_hi ? ST_LEN : ST_DONE;
            state_in = ST_CINIT;
         end
         ST_LEN: begin
            cmd.op   = OP_LEN;
            ret_in   = ST_DONE;
            state_in = ST_CINIT;
         end
         ST_DONE: begin
            if (st.kind == KIND_KEY) begin
               cmd.op   = OP_KEYHASH;
               state_in = ST_IDLE;
            end else if (st.msg_hmac && !outer_ff) begin
               cmd.op   = OP_OPAD;
               outer_in = 1'b1;
               ret_in   = ST_OUTER;
               state_in = ST_CINIT;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_OUTER: begin
            cmd.op   = OP_OUTER;
            ret_in   = ST_SEND;
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            cmd.op   = OP_CINIT;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.op = OP_ROUND;
            if (st.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.op   = OP_ADD;
            state_in = ret_ff;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               widx_in = widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  cmd.op   = OP_IV;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `HSHA_ASSERT_IMPL(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   `HSHA_ASSERT_NEXT(a_rounds_continue, clock, reset,
      (state_ff == ST_ROUND) && !st.round_last, state_ff == ST_ROUND)
   `HSHA_ASSERT_NEXT(a_last_word_idle, clock, reset,
      rsp_valid && rsp_ready && (widx_ff == 2'd3), (state_ff == ST_IDLE) && (widx_ff == 2'd0))

endmodule

### design/hmac_sha256_engine.sv
// A chunk is appended one byte at a time, after a start step when it opens a stream, and
// each 64-byte block it fills is compressed. A final message chunk adds one or two padding
// blocks, two outer compressions in HMAC mode, then four digest words; the HMAC ipad block
// is compressed as a message opens. Items go one at a time through the single round unit.
// Reset is synchronous and active high: empty key, plain mode, no stream open.
// ----------------------------------------------------------------------------
// hmac_sha256_engine
// Streaming SHA-256 and HMAC-SHA256 over 8-byte input words.
// ----------------------------------------------------------------------------
module hmac_sha256_engine
   import hsha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [63:0] req_chunk,
   input  logic [3:0]  req_byte_count,
   input  logic        req_final_chunk,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_hmac_mode
);

   cmd_type    cmd;
   status_type st;

   assign csr_ready      = 1'b1;
   assign rsp_word_index = cmd.widx;
   assign rsp_last_word  = (cmd.widx == 2'd3);

   hsha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   hsha_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_kind        (req_kind),
      .req_chunk       (req_chunk),
      .req_byte_count  (req_byte_count),
      .req_final_chunk (req_final_chunk),
      .csr_valid       (csr_valid),
      .csr_hmac_mode   (csr_hmac_mode),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine testbench
// Feeds key and message words into the engine in several idle and stall
// phases and in both modes, predicts each digest with a behavioral SHA-256
// and HMAC model kept in step with the accepted words, and checks every
// digest word against it in order.
// ----------------------------------------------------------------------------
module testbench
   import hsha_pkg::*;
();

   localparam int DRAIN_CYCLES = 600;
   localparam int STALL_LIMIT  = 5000;

   localparam logic [31:0] RK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct {
      logic        kind;
      logic [63:0] chunk;
      logic [3:0]  byte_count;
      logic        final_chunk;
   } chunk_word_type;

   typedef struct {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic [63:0] req_chunk = '0;
   logic [3:0] req_byte_count = '0;
   logic req_final_chunk = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [1:0] rsp_word_index;
   logic rsp_last_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_hmac_mode = 1'b0;

   chunk_word_type  pending_words[$];
   digest_word_type expected_digests[$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // Behavioral engine state.
   logic [63:0] key_k0 [8];
   logic [63:0] block_buf [8];
   logic [31:0] hash_state [8];
   logic [63:0] byte_total;
   logic key_long, stream_active, active_kind, active_hmac, mode_reg;

   hmac_sha256_engine DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 8; t++) begin
         w[2*t] = block_buf[t][63:32];
         w[2*t+1] = block_buf[t][31:0];
      end
      for (int t = 16; t < 64; t++) begin
         w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      end
      v = hash_state;
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) hash_state[t] += v[t];
   endfunction

   function automatic void set_byte(input int pos, input logic [7:0] b);
      block_buf[pos[5:3]][63 - 8*pos[2:0] -: 8] = b;
   endfunction

   function automatic void pad_and_close(input logic [63:0] total);
      int p;
      p = int'(total[5:0]);
      set_byte(p, PAD_BYTE);
      for (int i = p + 1; i < 64; i++) set_byte(i, 8'h00);
      if (p >= 56) begin
         sha_block();
         for (int i = 0; i < 8; i++) block_buf[i] = '0;
      end
      block_buf[7] = total << 3;
      sha_block();
   endfunction

   function automatic void load_key_pad(input logic [31:0] pad);
      for (int i = 0; i < 8; i++) block_buf[i] = key_k0[i] ^ {pad, pad};
   endfunction

   function automatic logic [63:0] state_word(input int i);
      return {hash_state[2*i], hash_state[2*i+1]};
   endfunction

   function automatic void engine_reset();
      for (int i = 0; i < 8; i++) begin
         key_k0[i] = '0;
         block_buf[i] = '0;
      end
      hash_state = IV_VAL;
      byte_total = '0;
      key_long = 1'b0;
      stream_active = 1'b0;
      active_kind = KIND_KEY;
      active_hmac = 1'b0;
      mode_reg = 1'b0;
   endfunction

   function automatic void engine_step(input chunk_word_type cw);
      int n;
      logic [63:0] inner [4];
      digest_word_type d;
      n = (cw.byte_count > 8) ? 8 : int'(cw.byte_count);
      if (!stream_active || active_kind != cw.kind) begin
         stream_active = 1'b1;
         active_kind = cw.kind;
         byte_total = '0;
         key_long = 1'b0;
         hash_state = IV_VAL;
         if (cw.kind == KIND_MSG) begin
            active_hmac = mode_reg;
            if (active_hmac) begin
               load_key_pad(IPAD_WORD);
               sha_block();
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         int pos;
         pos = int'(byte_total[5:0]);
         set_byte(pos, cw.chunk[63 - 8*i -: 8]);
         byte_total++;
         if (active_kind == KIND_KEY && byte_total > 64) key_long = 1'b1;
         if (pos == 63) sha_block();
      end
      if (!cw.final_chunk) return;
      stream_active = 1'b0;
      if (cw.kind == KIND_KEY) begin
         if (key_long) begin
            pad_and_close(byte_total);
            for (int i = 0; i < 4; i++) key_k0[i] = state_word(i);
            for (int i = 4; i < 8; i++) key_k0[i] = '0;
         end else begin
            if (byte_total < 64)
               for (int i = int'(byte_total); i < 64; i++) set_byte(i, 8'h00);
            key_k0 = block_buf;
         end
         hash_state = IV_VAL;
         return;
      end
      if (active_hmac) begin
         pad_and_close(byte_total + 64);
         for (int i = 0; i < 4; i++) inner[i] = state_word(i);
         hash_state = IV_VAL;
         load_key_pad(OPAD_WORD);
         sha_block();
         for (int i = 0; i < 4; i++) block_buf[i] = inner[i];
         block_buf[4] = {PAD_WORD, 32'h0};
         block_buf[5] = '0;
         block_buf[6] = '0;
         block_buf[7] = {32'h0, OUTER_BITS};
         sha_block();
      end else begin
         pad_and_close(byte_total);
      end
      for (int i = 0; i < 4; i++) begin
         d.digest_word = state_word(i);
         d.word_index = 2'(i);
         d.last_word = (i == 3);
         expected_digests.insert(expected_digests.size(), d);
      end
      hash_state = IV_VAL;
   endfunction

   task automatic push_word(input logic kind, input logic [63:0] chunk, input int bc,
                            input logic fin);
      chunk_word_type cw;
      cw.kind = kind;
      cw.chunk = chunk;
      cw.byte_count = 4'(bc);
      cw.final_chunk = fin;
      pending_words.insert(pending_words.size(), cw);
   endtask

   // Splits a stream of len bytes into words with random content.
   task automatic push_stream(input logic kind, input int len, inout int added);
      int left, n;
      left = len;
      while (left > 8 || ($urandom_range(7) == 0 && left > 0)) begin
         n = ($urandom_range(5) == 0) ? $urandom_range(1, 8) : 8;
         if (n > left) n = left;
         push_word(kind, {$urandom, $urandom}, n, 1'b0);
         left -= n;
         added++;
      end
      push_word(kind, {$urandom, $urandom}, (left == 8 && $urandom_range(3) == 0) ?
                $urandom_range(9, 15) : left, 1'b1);
      added++;
   endtask

   task automatic gen_random(input int count);
      int added, pick;
      added = 0;
      while (added < count) begin
         pick = $urandom_range(9);
         if (pick <= 1) push_stream(KIND_KEY, $urandom_range(0, 100), added);
         else if (pick <= 7)
            push_stream(KIND_MSG, ($urandom_range(3) == 0) ? $urandom_range(0, 140) :
                        $urandom_range(0, 40), added);
         else if (pick == 8) begin
            push_word(1'($urandom_range(1)), {$urandom, $urandom}, $urandom_range(15),
                      1'($urandom_range(1)));
            added++;
         end else begin
            push_word(KIND_MSG, {$urandom, $urandom}, 8, 1'b0);
            push_word(KIND_MSG, {$urandom, $urandom}, 8, 1'b0);
            added += 2;
            push_stream(KIND_KEY, $urandom_range(0, 70), added);
         end
      end
   endtask

   task automatic wait_drain();
      while (pending_words.size() != 0 || req_valid || expected_digests.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_hmac_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            chunk_word_type cw;
            cw = pending_words.pop_front();
            req_kind <= cw.kind;
            req_chunk <= cw.chunk;
            req_byte_count <= cw.byte_count;
            req_final_chunk <= cw.final_chunk;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         engine_reset();
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (csr_valid && csr_ready) mode_reg = csr_hmac_mode;
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               $error("unexpected digest word %h", rsp_digest_word);
               error_count++;
            end else begin
               digest_word_type d;
               d = expected_digests.pop_front();
               if (rsp_digest_word !== d.digest_word) begin
                  $error("digest_word expected %h actual %h", d.digest_word, rsp_digest_word);
                  error_count++;
               end
               if (rsp_word_index !== d.word_index) begin
                  $error("word_index expected %0d actual %0d", d.word_index, rsp_word_index);
                  error_count++;
               end
               if (rsp_last_word !== d.last_word) begin
                  $error("last_word expected %0d actual %0d", d.last_word, rsp_last_word);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            chunk_word_type cw;
            cw.kind = req_kind;
            cw.chunk = req_chunk;
            cw.byte_count = req_byte_count;
            cw.final_chunk = req_final_chunk;
            engine_step(cw);
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      push_word(KIND_MSG, 64'h6162_6300_0000_0000, 3, 1'b1);
      push_word(KIND_MSG, '0, 0, 1'b1);
      push_word(KIND_KEY, '1, 0, 1'b1);
      push_word(KIND_MSG, '1, 15, 1'b1);
      wait_drain();
      write_mode(1'b1);
      push_word(KIND_MSG, '0, 8, 1'b1);
      for (int i = 0; i < 9; i++) push_word(KIND_KEY, {$urandom, $urandom}, 8, 1'b0);
      push_word(KIND_KEY, '0, 0, 1'b1);
      push_word(KIND_MSG, '1, 3, 1'b0);
      push_word(KIND_MSG, {$urandom, $urandom}, 5, 1'b1);
      push_word(KIND_MSG, '1, 8, 1'b0);
      push_word(KIND_KEY, 64'h0123_4567_89ab_cdef, 4, 1'b1);
      push_word(KIND_MSG, '0, 8, 1'b0);
      wait_drain();
      // The mode was sampled when the message opened, so this one stays HMAC.
      write_mode(1'b0);
      push_word(KIND_MSG, '1, 2, 1'b1);
      wait_drain();

      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = (ph == 1) ? 72 : (ph == 3) ? 38 : 0;
         receiver_stall_pct = (ph == 2) ? 72 : (ph == 3) ? 38 : 0;
         write_mode(ph[0] ? 1'b0 : 1'b1);
         gen_random(22);
         wait_drain();
      end

      if (expected_digests.size() != 0) error_count++;
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/hsha_pkg.sv
design/hsha_datapath.sv
design/hsha_ctrl.sv
design/hmac_sha256_engine.sv
sim/testbench.sv
